[rtl/register_link_master_crc16_macros.svh]
// Assertion helpers used by the checker file.
`ifndef REGISTER_LINK_MASTER_CRC16_MACROS_SVH
`define REGISTER_LINK_MASTER_CRC16_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define RLM_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Condition that must hold in the cycle after reset is seen.
`define RLM_ASSERT_RST(lbl, cons, msg) \
   lbl: assert property (@(posedge clock) reset |=> (cons)) else $error(msg);

`endif

[rtl/rlm_pkg.sv]
`timescale 1ns / 1ps
package rlm_pkg;

   localparam int unsigned REPLY_LEN = 6;
   localparam int unsigned PKT_LEN   = 5;
   localparam int unsigned QDEPTH    = 2;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   // request/input kinds, coded as on req_tuser
   typedef enum logic [1:0] {
      KIND_READ  = 2'd0,
      KIND_WRITE = 2'd1,
      KIND_BYTE  = 2'd2,
      KIND_TICK  = 2'd3
   } kind_type;

   // result kinds, coded as on rsp_tuser
   localparam logic OUT_TX     = 1'b0;
   localparam logic OUT_REPORT = 1'b1;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_TIMEOUT = 2'd1;
   localparam logic [1:0] ST_CRC     = 2'd2;

   // register indexes on the csr port
   localparam logic CSR_ATTEMPT_LIMIT = 1'b0;
   localparam logic CSR_TIMEOUT_TICKS = 1'b1;

   localparam int unsigned REQ_DATA_W = 24;
   localparam int unsigned RSP_DATA_W = 48;

   // classified item as queued between front and back
   typedef struct packed {
      kind_type   kind;
      logic [7:0] header;   // write flag and register number
      logic [7:0] data;     // value byte of a request, or the received byte
      logic       retry;
   } item_type;

   typedef struct packed {
      logic       valid;
      logic       index;
      logic [7:0] data;
   } csr_wr_type;

   // one byte through the reflected CRC-16
   function automatic logic [15:0] crc16_byte(input logic [15:0] c_in,
                                              input logic [7:0]  b);
      logic [15:0] c;
      c = c_in ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = {1'b0, c[15:1]} ^ CRC_POLY;
         end else begin
            c = {1'b0, c[15:1]};
         end
      end
      return c;
   endfunction

endpackage

[rtl/register_link_master_crc16.sv]
`timescale 1ns / 1ps
// Register link master with CRC-16 framing.
// req_*: one beat per event: tuser 0 read request, 1 write request,
//   2 byte received from the slave, 3 timer tick.
// rsp_*: tuser 0 is a byte to transmit (five per packet, tlast on the
//   second CRC byte), tuser 1 is a completion report (always tlast).
// csr_*: index 0 attempt limit, 1 timeout in ticks; write only while idle.
// Beats go into a two-entry queue; the sequencer behind it takes one beat
// per cycle while idle or awaiting a reply, if the output register is free.
// A request is loaded as a packet, then sent byte by byte; bytes leave one
// per cycle through the single output register while rsp_tready allows,
// and the CRC is folded in byte by byte. A completion report is registered
// in the cycle after the closing byte or tick reaches the sequencer.
// Reset empties the queue, drops any pending output, returns to idle and
// restores attempt limit 3, timeout 2 and a zero failure count.
// When a beat is pending and rsp_tready is low, the output register holds;
// the sequencer stops and the queue fills, after which req_tready drops.
module register_link_master_crc16
   import rlm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [6:0] reg_number, [14:7] write_value, [15] use_retries, [23:16] rx_byte
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // [1:0] req_type
   input  logic [1:0]            req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [7:0] tx_byte, [9:8] status, [25:10] reply_value, [41:26] fail_count
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // [0] out_kind
   output logic                  rsp_tuser,
   output logic                  rsp_tlast,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic                  csr_index,
   input  logic [7:0]            csr_data
);

   logic        q_valid;
   item_type    q_item;
   logic        q_pop;
   csr_wr_type  csr;
   logic [7:0]  tx_byte;
   logic [1:0]  status;
   logic [15:0] reply_value;
   logic [15:0] fail_count;

   assign csr_ready = 1'b1;
   assign csr.valid = csr_valid;
   assign csr.index = csr_index;
   assign csr.data  = csr_data;

   rlm_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_kind  (req_tuser),
      .in_data  (req_tdata),
      .q_valid  (q_valid),
      .q_item   (q_item),
      .q_pop    (q_pop)
   );

   rlm_back u_back (
      .clock           (clock),
      .reset           (reset),
      .csr             (csr),
      .q_valid         (q_valid),
      .q_item          (q_item),
      .q_pop           (q_pop),
      .out_valid       (rsp_tvalid),
      .out_ready       (rsp_tready),
      .out_kind        (rsp_tuser),
      .out_tx_byte     (tx_byte),
      .out_last        (rsp_tlast),
      .out_status      (status),
      .out_reply_value (reply_value),
      .out_fail_count  (fail_count)
   );

   assign rsp_tdata = {6'b000000, fail_count, reply_value, status, tx_byte};

endmodule

[rtl/rlm_front.sv]
`timescale 1ns / 1ps
module rlm_front
   import rlm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  logic [1:0]  in_kind,
   input  logic [REQ_DATA_W-1:0] in_data,
   output logic        q_valid,
   output item_type    q_item,
   input  logic        q_pop
);

   item_type   mem_ff [QDEPTH];
   item_type   item_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   // classify: build header and value byte here so the back end only sequences
   always_comb begin
      item_in.kind   = kind_type'(in_kind);
      item_in.header = {in_kind[0], in_data[6:0]};
      item_in.retry  = in_data[15];
      case (kind_type'(in_kind))
         KIND_READ:  item_in.data = 8'h01;
         KIND_WRITE: item_in.data = in_data[14:7];
         KIND_BYTE:  item_in.data = in_data[23:16];
         default:    item_in.data = 8'h00;
      endcase
   end

   assign in_ready = (count_ff != 2'(QDEPTH));
   assign push     = in_valid & in_ready;
   assign q_valid  = (count_ff != 2'd0);
   assign pop      = q_pop & q_valid;
   assign q_item   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= item_in;
      end
   end

endmodule

[rtl/rlm_back.sv]
`timescale 1ns / 1ps
module rlm_back
   import rlm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  csr_wr_type  csr,
   input  logic        q_valid,
   input  item_type    q_item,
   output logic        q_pop,
   output logic        out_valid,
   input  logic        out_ready,
   output logic        out_kind,
   output logic [7:0]  out_tx_byte,
   output logic        out_last,
   output logic [1:0]  out_status,
   output logic [15:0] out_reply_value,
   output logic [15:0] out_fail_count
);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_SEND = 3'b010,
      S_WAIT = 3'b100
   } state_type;

   state_type   state_ff, state_in;
   logic [2:0]  limit_ff, limit_in;
   logic [7:0]  timeout_ff, timeout_in;
   logic [2:0]  idx_ff, idx_in;
   logic [2:0]  attempts_ff, attempts_in;
   logic [2:0]  rx_ff, rx_in;
   logic [7:0]  tick_ff, tick_in;
   logic [15:0] failures_ff, failures_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  header_ff, header_in;
   logic [7:0]  value_ff, value_in;
   logic        retry_ff, retry_in;
   logic [7:0]  lo_ff, lo_in;
   logic [7:0]  hi_ff, hi_in;
   logic [7:0]  crclo_ff, crclo_in;

   logic        valid_ff, valid_in;
   logic        kind_ff, kind_in;
   logic [7:0]  txb_ff, txb_in;
   logic        last_ff, last_in;
   logic [1:0]  status_ff, status_in;
   logic [15:0] value16_ff, value16_in;
   logic [15:0] fcount_ff, fcount_in;

   logic        slot_free;
   logic        emit;
   logic        fail;
   logic [1:0]  fail_st;
   logic [2:0]  lim;
   logic [7:0]  tick_next;
   logic [7:0]  send_byte;

   assign slot_free = ~valid_ff | out_ready;
   assign lim       = (limit_ff == 3'd0) ? 3'd1 : limit_ff;
   assign tick_next = (tick_ff == 8'hFF) ? tick_ff : tick_ff + 8'd1;

   always_comb begin
      case (idx_ff)
         3'd0:    send_byte = header_ff;
         3'd1:    send_byte = value_ff;
         3'd3:    send_byte = crc_ff[7:0];
         3'd4:    send_byte = crc_ff[15:8];
         default: send_byte = 8'h00;
      endcase
   end

   always_comb begin
      limit_in    = limit_ff;
      timeout_in  = timeout_ff;
      state_in    = state_ff;
      idx_in      = idx_ff;
      attempts_in = attempts_ff;
      rx_in       = rx_ff;
      tick_in     = tick_ff;
      failures_in = failures_ff;
      crc_in      = crc_ff;
      header_in   = header_ff;
      value_in    = value_ff;
      retry_in    = retry_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      crclo_in    = crclo_ff;
      q_pop       = 1'b0;
      emit        = 1'b0;
      fail        = 1'b0;
      fail_st     = ST_OK;
      kind_in     = kind_ff;
      txb_in      = txb_ff;
      last_in     = last_ff;
      status_in   = status_ff;
      value16_in  = value16_ff;
      fcount_in   = fcount_ff;

      if (csr.valid) begin
         if (csr.index == CSR_ATTEMPT_LIMIT) begin
            limit_in = csr.data[2:0];
         end else begin
            timeout_in = csr.data;
         end
      end

      case (state_ff)
         S_SEND: begin
            if (slot_free) begin
               emit       = 1'b1;
               kind_in    = OUT_TX;
               txb_in     = send_byte;
               last_in    = (idx_ff == 3'(PKT_LEN - 1));
               status_in  = ST_OK;
               value16_in = 16'h0000;
               fcount_in  = 16'h0000;
               if (idx_ff < 3'(PKT_LEN - 2)) begin
                  crc_in = crc16_byte(crc_ff, send_byte);
               end
               if (idx_ff == 3'(PKT_LEN - 1)) begin
                  state_in = S_WAIT;
                  crc_in   = CRC_INIT;
                  rx_in    = 3'd0;
                  tick_in  = 8'd0;
               end else begin
                  idx_in = idx_ff + 3'd1;
               end
            end
         end
         S_IDLE: begin
            if (q_valid && slot_free) begin
               q_pop = 1'b1;
               if (q_item.kind == KIND_READ || q_item.kind == KIND_WRITE) begin
                  header_in   = q_item.header;
                  value_in    = q_item.data;
                  retry_in    = q_item.retry;
                  attempts_in = 3'd1;
                  state_in    = S_SEND;
                  idx_in      = 3'd0;
                  crc_in      = CRC_INIT;
               end
            end
         end
         S_WAIT: begin
            if (q_valid && slot_free) begin
               q_pop = 1'b1;
               case (q_item.kind)
                  KIND_BYTE: begin
                     if (rx_ff < 3'd4) begin
                        crc_in = crc16_byte(crc_ff, q_item.data);
                     end
                     if (rx_ff == 3'd2) lo_in = q_item.data;
                     if (rx_ff == 3'd3) hi_in = q_item.data;
                     if (rx_ff == 3'd4) crclo_in = q_item.data;
                     if (rx_ff == 3'(REPLY_LEN - 1)) begin
                        if ({q_item.data, crclo_ff} == crc_ff) begin
                           emit       = 1'b1;
                           kind_in    = OUT_REPORT;
                           txb_in     = 8'h00;
                           last_in    = 1'b1;
                           status_in  = ST_OK;
                           value16_in = {hi_ff, lo_ff};
                           fcount_in  = failures_ff;
                           state_in   = S_IDLE;
                        end else begin
                           fail    = 1'b1;
                           fail_st = ST_CRC;
                        end
                     end else begin
                        rx_in = rx_ff + 3'd1;
                     end
                  end
                  KIND_TICK: begin
                     tick_in = tick_next;
                     if (tick_next >= timeout_ff) begin
                        fail    = 1'b1;
                        fail_st = ST_TIMEOUT;
                     end
                  end
                  default: ;  // requests while a reply is awaited are dropped
               endcase
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (fail) begin
         if (retry_ff && attempts_ff < lim) begin
            attempts_in = attempts_ff + 3'd1;
            state_in    = S_SEND;
            idx_in      = 3'd0;
            crc_in      = CRC_INIT;
         end else begin
            if (retry_ff && failures_ff != 16'hFFFF) begin
               failures_in = failures_ff + 16'd1;
            end
            emit       = 1'b1;
            kind_in    = OUT_REPORT;
            txb_in     = 8'h00;
            last_in    = 1'b1;
            status_in  = fail_st;
            value16_in = 16'h0000;
            fcount_in  = failures_in;
            state_in   = S_IDLE;
         end
      end

      valid_in = emit | (valid_ff & ~out_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         limit_ff    <= 3'd3;
         timeout_ff  <= 8'd2;
         idx_ff      <= 3'd0;
         attempts_ff <= 3'd0;
         rx_ff       <= 3'd0;
         tick_ff     <= 8'd0;
         failures_ff <= 16'd0;
         retry_ff    <= 1'b0;
         valid_ff    <= 1'b0;
      end else begin
         state_ff    <= state_in;
         limit_ff    <= limit_in;
         timeout_ff  <= timeout_in;
         idx_ff      <= idx_in;
         attempts_ff <= attempts_in;
         rx_ff       <= rx_in;
         tick_ff     <= tick_in;
         failures_ff <= failures_in;
         retry_ff    <= retry_in;
         valid_ff    <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      crc_ff     <= crc_in;
      header_ff  <= header_in;
      value_ff   <= value_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      crclo_ff   <= crclo_in;
      kind_ff    <= kind_in;
      txb_ff     <= txb_in;
      last_ff    <= last_in;
      status_ff  <= status_in;
      value16_ff <= value16_in;
      fcount_ff  <= fcount_in;
   end

   assign out_valid       = valid_ff;
   assign out_kind        = kind_ff;
   assign out_tx_byte     = txb_ff;
   assign out_last        = last_ff;
   assign out_status      = status_ff;
   assign out_reply_value = value16_ff;
   assign out_fail_count  = fcount_ff;

endmodule

[rtl/rlm_checker.sv]
`timescale 1ns / 1ps
`include "register_link_master_crc16_macros.svh"
module rlm_checker
   import rlm_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tuser,
   input logic                  rsp_tlast
);

   logic        tx_beat;
   logic        rpt_beat;
   logic        rpt_fail;
   logic        st_known;
   logic [7:0]  rsp_tx;
   logic [1:0]  rsp_st;
   logic [15:0] rsp_val;

   assign rsp_tx   = rsp_tdata[7:0];
   assign rsp_st   = rsp_tdata[9:8];
   assign rsp_val  = rsp_tdata[25:10];
   assign tx_beat  = rsp_tvalid && (rsp_tuser == OUT_TX);
   assign rpt_beat = rsp_tvalid && (rsp_tuser == OUT_REPORT);
   assign rpt_fail = rpt_beat && (rsp_st != ST_OK);
   assign st_known = (rsp_st == ST_TIMEOUT) || (rsp_st == ST_CRC);

   `RLM_ASSERT_RST(a_reset_clears, !rsp_tvalid && req_tready, "reset left state behind")

   `RLM_ASSERT_IMP(a_tx_clean, tx_beat, rsp_tdata[41:8] == 34'd0, "tx beat has report fields")

   `RLM_ASSERT_IMP(a_report_last, rpt_beat, rsp_tlast && rsp_tx == 8'h00, "bad report framing")

   `RLM_ASSERT_IMP(a_fail_value, rpt_fail, st_known && rsp_val == 16'h0, "bad failure report")

endmodule

bind register_link_master_crc16 rlm_checker u_rlm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

[bench/tb_register_link_master_crc16.sv]
`timescale 1ns / 1ps
module tb_register_link_master_crc16;
   import rlm_pkg::*;

   localparam int SETTLE_CYCLES = 16;
   localparam int STALL_LIMIT   = 4000;
   localparam int RANDOM_ITEMS  = 290;
   localparam int PHASE_ITEMS   = 45;

   typedef struct packed {
      logic        kind;
      logic [7:0]  tx;
      logic        last;
      logic [1:0]  status;
      logic [15:0] value;
      logic [15:0] fails;
   } link_beat_type;

   // reflected CRC-16, one byte at a time
   function automatic logic [15:0] crc16_step(logic [15:0] c_in, logic [7:0] b);
      logic [15:0] c;
      c = c_in ^ {8'h00, b};
      repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      return c;
   endfunction

   class link_scoreboard;
      link_beat_type expected_q[$];
      int          errors;
      int          tx_beats;
      int          ok_reports;
      int          timeout_reports;
      int          crc_reports;
      logic [2:0]  attempt_limit;
      logic [7:0]  timeout_ticks;
      logic        waiting;
      logic [7:0]  header;
      logic [7:0]  value;
      logic        retry;
      logic [2:0]  attempts;
      logic [2:0]  rx_count;
      logic [7:0]  reply[REPLY_LEN];
      logic [7:0]  ticks;
      logic [15:0] failures;

      function new();
         attempt_limit = 3'd3;
         timeout_ticks = 8'd2;
         waiting = 1'b0;
         header = 8'h00;
         value = 8'h00;
         retry = 1'b0;
         attempts = 3'd0;
         rx_count = 3'd0;
         ticks = 8'd0;
         failures = 16'd0;
      endfunction

      function void push(logic kind, logic [7:0] tx, logic last, logic [1:0] st,
                         logic [15:0] val, logic [15:0] fc);
         link_beat_type e;
         e.kind = kind;
         e.tx = tx;
         e.last = last;
         e.status = st;
         e.value = val;
         e.fails = fc;
         expected_q.push_back(e);
      endfunction

      function void send_packet();
         logic [15:0] c;
         c = crc16_step(CRC_INIT, header);
         c = crc16_step(c, value);
         c = crc16_step(c, 8'h00);
         push(OUT_TX, header, 1'b0, ST_OK, 16'h0, 16'h0);
         push(OUT_TX, value, 1'b0, ST_OK, 16'h0, 16'h0);
         push(OUT_TX, 8'h00, 1'b0, ST_OK, 16'h0, 16'h0);
         push(OUT_TX, c[7:0], 1'b0, ST_OK, 16'h0, 16'h0);
         push(OUT_TX, c[15:8], 1'b1, ST_OK, 16'h0, 16'h0);
         rx_count = 3'd0;
         ticks = 8'd0;
         waiting = 1'b1;
      endfunction

      function void attempt_failed(logic [1:0] st);
         logic [2:0] lim;
         lim = (attempt_limit == 3'd0) ? 3'd1 : attempt_limit;
         if (retry && attempts < lim) begin
            attempts = attempts + 3'd1;
            send_packet();
         end else begin
            // only retried requests count toward the failure total
            if (retry && failures != 16'hFFFF) failures = failures + 16'd1;
            waiting = 1'b0;
            push(OUT_REPORT, 8'h00, 1'b1, st, 16'h0, failures);
         end
      endfunction

      function void note_input(logic [1:0] user, logic [23:0] d);
         kind_type    k;
         logic [15:0] c;
         logic [15:0] got;
         k = kind_type'(user);
         if (k == KIND_READ || k == KIND_WRITE) begin
            if (!waiting) begin
               header = {k == KIND_WRITE, d[6:0]};
               value = (k == KIND_WRITE) ? d[14:7] : 8'd1;
               retry = d[15];
               attempts = 3'd1;
               send_packet();
            end
         end else if (waiting) begin
            if (k == KIND_BYTE) begin
               if (rx_count < REPLY_LEN) reply[rx_count] = d[23:16];
               rx_count = rx_count + 3'd1;
               if (rx_count >= REPLY_LEN) begin
                  c = CRC_INIT;
                  for (int i = 0; i < 4; i++) c = crc16_step(c, reply[i]);
                  got = {reply[5], reply[4]};
                  if (c != got) begin
                     attempt_failed(ST_CRC);
                  end else begin
                     waiting = 1'b0;
                     push(OUT_REPORT, 8'h00, 1'b1, ST_OK, {reply[3], reply[2]}, failures);
                  end
               end
            end else begin
               if (ticks != 8'hFF) ticks = ticks + 8'd1;
               if (ticks >= timeout_ticks) attempt_failed(ST_TIMEOUT);
            end
         end
      endfunction

      function void write_reg(logic idx, logic [7:0] v);
         if (idx == CSR_ATTEMPT_LIMIT) attempt_limit = v[2:0];
         else timeout_ticks = v;
      endfunction

      function void compare(string field, logic [15:0] want, logic [15:0] got);
         if (got !== want) begin
            $error("%s: expected %0h, got %0h", field, want, got);
            errors++;
         end
      endfunction

      function void check_result(logic user, logic lastf, logic [RSP_DATA_W-1:0] d);
         link_beat_type e;
         if (expected_q.size() == 0) begin
            $error("result beat with nothing expected: kind %0d tdata %h", user, d);
            errors++;
         end else begin
            e = expected_q.pop_front();
            compare("out_kind", 16'(e.kind), 16'(user));
            compare("tx_byte", 16'(e.tx), 16'(d[7:0]));
            compare("last", 16'(e.last), 16'(lastf));
            compare("status", 16'(e.status), 16'(d[9:8]));
            compare("reply_value", e.value, d[25:10]);
            compare("fail_count", e.fails, d[41:26]);
            compare("tdata padding", 16'h0, 16'(d[47:42]));
            if (e.kind == OUT_TX) tx_beats++;
            else if (e.status == ST_OK) ok_reports++;
            else if (e.status == ST_TIMEOUT) timeout_reports++;
            else crc_reports++;
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [1:0]            req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic                  csr_index = 1'b0;
   logic [7:0]            csr_data = '0;

   register_link_master_crc16 dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   link_scoreboard link_sb;
   int             burst_left = 0;
   int             items_sent = 0;
   int             settings_used = 0;
   int             cur_limit = 3;
   int             cur_timeout = 2;
   int             idle_cycles = 0;
   logic [9:0]     stall_phase = '0;

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) link_sb.note_input(req_tuser, req_tdata);
         if (rsp_tvalid && rsp_tready) link_sb.check_result(rsp_tuser, rsp_tlast, rsp_tdata);
         if (csr_valid && csr_ready) link_sb.write_reg(csr_index, csr_data);
      end
   end

   // receiver back-pressure: free, random, sparse and long stalls in turn
   always @(posedge clock) begin
      stall_phase <= stall_phase + 10'd1;
      case (stall_phase[9:8])
         2'd0: rsp_tready <= 1'b1;
         2'd1: rsp_tready <= ($urandom_range(0, 3) != 0);
         2'd2: rsp_tready <= (stall_phase[1:0] == 2'd0);
         default: rsp_tready <= ~stall_phase[4];
      endcase
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
         $display("register_link_master_crc16 verification failed");
         $finish;
      end
   end

   task automatic send_beat(kind_type k, logic [REQ_DATA_W-1:0] d);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser <= k;
      req_tdata <= d;
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   task automatic send_request(kind_type k, logic [6:0] r, logic [7:0] w, logic rt);
      send_beat(k, {8'($urandom), rt, w, r});
   endtask

   task automatic send_rx(logic [7:0] b);
      send_beat(KIND_BYTE, {b, 16'($urandom)});
   endtask

   task automatic send_ticks(int n);
      repeat (n) send_beat(KIND_TICK, 24'($urandom));
   endtask

   function automatic logic [15:0] pick_value();
      case ($urandom_range(0, 3))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   // six-byte reply with a valid CRC, optionally one bit flipped, ticks mixed in
   task automatic send_reply(logic [15:0] val, logic corrupt, int early_ticks);
      logic [7:0]  bytes[REPLY_LEN];
      logic [15:0] c;
      int          pos;
      int          left;
      bytes[0] = 8'($urandom);
      bytes[1] = 8'($urandom);
      bytes[2] = val[7:0];
      bytes[3] = val[15:8];
      c = CRC_INIT;
      for (int i = 0; i < 4; i++) c = crc16_step(c, bytes[i]);
      bytes[4] = c[7:0];
      bytes[5] = c[15:8];
      if (corrupt) begin
         pos = $urandom_range(0, REPLY_LEN - 1);
         bytes[pos] = bytes[pos] ^ (8'd1 << $urandom_range(0, 7));
      end
      left = early_ticks;
      for (int i = 0; i < REPLY_LEN; i++) begin
         if (left > 0 && $urandom_range(0, 2) == 0) begin
            send_ticks(1);
            left--;
         end
         send_rx(bytes[i]);
      end
   endtask

   task automatic run_transaction();
      kind_type k;
      logic     rt;
      int       lim;
      int       outcome;
      int       early;
      int       expire;
      k = ($urandom_range(0, 1) != 0) ? KIND_WRITE : KIND_READ;
      rt = 1'($urandom_range(0, 1));
      send_request(k, 7'($urandom), 8'($urandom), rt);
      lim = rt ? ((cur_limit == 0) ? 1 : cur_limit) : 1;
      expire = (cur_timeout == 0) ? 1 : cur_timeout;
      for (int a = 0; a < lim; a++) begin
         // a request while the reply is awaited must be dropped
         if ($urandom_range(0, 9) == 0) begin
            send_request(($urandom_range(0, 1) != 0) ? KIND_WRITE : KIND_READ,
                         7'($urandom), 8'($urandom), 1'($urandom));
         end
         early = (cur_timeout > 1) ?
                 $urandom_range(0, (cur_timeout > 4) ? 3 : cur_timeout - 1) : 0;
         outcome = $urandom_range(0, 9);
         if (cur_timeout > 8 && outcome >= 7 && $urandom_range(0, 3) != 0) outcome = 0;
         if (outcome <= 4) begin
            send_reply(pick_value(), 1'b0, early);
            break;
         end else if (outcome <= 6) begin
            send_reply(pick_value(), 1'b1, early);
         end else if (outcome == 7) begin
            send_ticks(expire);
         end else begin
            repeat ($urandom_range(1, REPLY_LEN - 1)) send_rx(8'($urandom));
            send_ticks(expire);
         end
      end
   endtask

   // stop driving, wait for every expected beat, then let the block settle
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (link_sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [7:0] v);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic reconfigure(int lim, int tmo);
      drain();
      // close out an open exchange so the link is idle for the write
      while (link_sb.waiting) begin
         send_reply(pick_value(), 1'b0, 0);
         drain();
      end
      write_csr(CSR_ATTEMPT_LIMIT, 8'(lim));
      write_csr(CSR_TIMEOUT_TICKS, 8'(tmo));
      csr_valid <= 1'b0;
      cur_limit = lim;
      cur_timeout = tmo;
      settings_used++;
   endtask

   initial begin
      int lim_set[7];
      int tmo_set[7];
      int rand_start;
      int phase_start;
      int p;
      lim_set = '{7, 1, 0, 5, 2, 7, 4};
      tmo_set = '{255, 1, 0, 3, 6, 2, 4};
      link_sb = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: idle noise, read, plain failure, retried failure with busy request
      send_rx(8'hA5);
      send_ticks(1);
      send_request(KIND_READ, 7'h7F, 8'h00, 1'b0);
      send_reply(16'hFFFF, 1'b0, 0);
      send_request(KIND_WRITE, 7'h00, 8'hFF, 1'b0);
      send_ticks(2);
      send_request(KIND_WRITE, 7'h55, 8'h00, 1'b1);
      send_request(KIND_READ, 7'h2A, 8'h5A, 1'b1);
      send_reply(16'h0000, 1'b1, 0);
      send_ticks(2);
      send_ticks(2);

      rand_start = items_sent;
      p = 0;
      while (items_sent - rand_start < RANDOM_ITEMS) begin
         if (p < 7) reconfigure(lim_set[p], tmo_set[p]);
         else reconfigure($urandom_range(1, 7), $urandom_range(1, 8));
         p++;
         phase_start = items_sent;
         while (items_sent - phase_start < PHASE_ITEMS &&
                items_sent - rand_start < RANDOM_ITEMS) begin
            if ($urandom_range(0, 9) == 0) begin
               if ($urandom_range(0, 1) != 0) send_rx(8'($urandom));
               else send_ticks(1);
            end
            run_transaction();
         end
      end

      drain();
      if (link_sb.pending() != 0) begin
         $error("%0d expected beats never arrived", link_sb.pending());
         link_sb.errors++;
      end
      $display("%0d request-side beats over %0d register settings; %0d transmit beats checked",
               items_sent, settings_used, link_sb.tx_beats);
      $display("reports checked: %0d ok, %0d timeout, %0d crc mismatch",
               link_sb.ok_reports, link_sb.timeout_reports, link_sb.crc_reports);
      if (link_sb.errors == 0) begin
         $display("register_link_master_crc16 verification clean");
      end else begin
         $display("register_link_master_crc16 verification failed");
      end
      $finish;
   end

endmodule

[register_link_master_crc16.f]
+incdir+rtl
rtl/rlm_pkg.sv
rtl/rlm_front.sv
rtl/rlm_back.sv
rtl/register_link_master_crc16.sv
rtl/rlm_checker.sv
bench/tb_register_link_master_crc16.sv
